/* sv/rvx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvx_pkg: shared constants and types for the RV32I subset execute unit
// Opcode and function codes of the supported subset, field widths and the
// record of one executed instruction.
// ----------------------------------------------------------------------------
package rvx_pkg;

   localparam int unsigned XlenBits = 32;
   localparam int unsigned RegIdxBits = 5;
   localparam int unsigned RegCount = 1 << RegIdxBits;

   typedef logic [XlenBits-1:0] word_type;
   typedef logic [RegIdxBits-1:0] reg_idx_type;
   typedef logic [6:0] opcode_type;
   typedef logic [2:0] funct3_type;
   typedef logic [6:0] funct7_type;

   localparam opcode_type OpcOp = 7'h33;
   localparam opcode_type OpcOpImm = 7'h13;
   localparam opcode_type OpcBranch = 7'h63;

   localparam funct3_type F3AddSub = 3'd0;
   localparam funct3_type F3Or = 3'd6;
   localparam funct3_type F3And = 3'd7;
   localparam funct3_type F3Beq = 3'd0;
   localparam funct3_type F3Addi = 3'd0;

   localparam funct7_type F7Base = 7'h00;
   localparam funct7_type F7Alt = 7'h20;

   localparam word_type PcStep = 32'd4;

   // Outcome of one instruction as it leaves the execute stage.
   typedef struct packed {
      word_type    next_pc;
      logic        wrote_reg;
      reg_idx_type dest_index;
      word_type    dest_value;
      logic        branch_taken;
      logic        unsupported;
   } exec_result_type;

endpackage
`default_nettype wire

/* sv/rv32i_subset_execute_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit: executes ADD/SUB/AND/OR/ADDI/BEQ on a 32-entry
// register file held in a synchronous memory, plus a program counter.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_instr_word) carries one raw
//   instruction word per item, fetched at the current pc.
//   Response channel (rsp_valid / rsp_stall / rsp_*) returns one item per
//   instruction: next pc, register write (if any), branch outcome and the
//   unsupported-opcode flag.
//   Each item passes the read-stage and result registers. Throughput: one
//   item per cycle while the receiver does not stall, set by the single read
//   stage of the register file memory (two read ports, read data registered)
//   followed by the execute/write-back stage. A write-back landing on the same
//   edge as the next item's read is forwarded from a last-write register.
//   Reset clears the pc, the per-entry valid bits of the register file (an
//   entry not yet written reads as zero), and both pipeline valid flags; no
//   clearing pass is needed.
//   When the receiver stalls, the result register holds, the execute stage
//   holds its item, and req_stall rises only once both are full.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr_word,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_wrote_reg,
   output logic [4:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic             rsp_branch_taken,
   output logic             rsp_unsupported
);

   // -------------------------------------------------------------------------
   // Storage
   // -------------------------------------------------------------------------
   // register file memory: one write port, two registered read ports
   rvx_pkg::word_type gpr_mem_ff [rvx_pkg::RegCount];
   // per-entry written flags; unwritten entries read as zero
   logic [rvx_pkg::RegCount-1:0] gpr_ok_ff;

   rvx_pkg::word_type pc_ff, pc_in;

   // execute stage
   logic              s1_valid_ff;
   logic [31:0]       s1_instr_ff;
   rvx_pkg::word_type s1_rs1_raw_ff, s1_rs2_raw_ff;
   logic              s1_rs1_ok_ff, s1_rs2_ok_ff;

   // most recent register file write, for forwarding
   logic                 fwd_en_ff;
   rvx_pkg::reg_idx_type fwd_idx_ff;
   rvx_pkg::word_type    fwd_val_ff;

   // response register
   logic                     out_valid_ff;
   rvx_pkg::exec_result_type out_ff, out_in;

   // -------------------------------------------------------------------------
   // Handshake
   // -------------------------------------------------------------------------
   logic s1_advance;
   logic req_accept;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   // -------------------------------------------------------------------------
   // Read stage: issue both source reads as the item is accepted
   // -------------------------------------------------------------------------
   rvx_pkg::reg_idx_type req_rs1, req_rs2;

   assign req_rs1 = req_instr_word[19:15];
   assign req_rs2 = req_instr_word[24:20];

   // -------------------------------------------------------------------------
   // Execute stage
   // -------------------------------------------------------------------------
   rvx_pkg::opcode_type  opc;
   rvx_pkg::funct3_type  f3;
   rvx_pkg::funct7_type  f7;
   rvx_pkg::reg_idx_type rd, rs1, rs2;
   rvx_pkg::word_type    op_a, op_b;
   rvx_pkg::word_type    imm_i, imm_b;
   logic                 wr_req;
   rvx_pkg::word_type    wr_val;
   logic                 wr_fire;

   assign opc = s1_instr_ff[6:0];
   assign rd  = s1_instr_ff[11:7];
   assign f3  = s1_instr_ff[14:12];
   assign rs1 = s1_instr_ff[19:15];
   assign rs2 = s1_instr_ff[24:20];
   assign f7  = s1_instr_ff[31:25];

   assign imm_i = {{20{s1_instr_ff[31]}}, s1_instr_ff[31:20]};
   assign imm_b = {{19{s1_instr_ff[31]}}, s1_instr_ff[31], s1_instr_ff[7],
                   s1_instr_ff[30:25], s1_instr_ff[11:8], 1'b0};

   // x0 reads zero; take a write that landed at the read edge from the bypass
   always_comb begin
      if (rs1 == '0) begin
         op_a = '0;
      end else if (fwd_en_ff && fwd_idx_ff == rs1) begin
         op_a = fwd_val_ff;
      end else begin
         op_a = s1_rs1_ok_ff ? s1_rs1_raw_ff : '0;
      end
      if (rs2 == '0) begin
         op_b = '0;
      end else if (fwd_en_ff && fwd_idx_ff == rs2) begin
         op_b = fwd_val_ff;
      end else begin
         op_b = s1_rs2_ok_ff ? s1_rs2_raw_ff : '0;
      end
   end

   always_comb begin
      wr_req = 1'b0;
      wr_val = '0;
      out_in = '0;
      out_in.next_pc = pc_ff + rvx_pkg::PcStep;
      priority if (opc == rvx_pkg::OpcOp) begin
         priority if (f3 == rvx_pkg::F3AddSub && f7 == rvx_pkg::F7Base) begin
            wr_req = 1'b1;
            wr_val = op_a + op_b;
         end else if (f3 == rvx_pkg::F3AddSub && f7 == rvx_pkg::F7Alt) begin
            wr_req = 1'b1;
            wr_val = op_a - op_b;
         end else if (f3 == rvx_pkg::F3And && f7 == rvx_pkg::F7Base) begin
            wr_req = 1'b1;
            wr_val = op_a & op_b;
         end else if (f3 == rvx_pkg::F3Or && f7 == rvx_pkg::F7Base) begin
            wr_req = 1'b1;
            wr_val = op_a | op_b;
         end else begin
            // unmatched R-type: no write, pc steps
            wr_req = 1'b0;
         end
      end else if (opc == rvx_pkg::OpcOpImm) begin
         if (f3 == rvx_pkg::F3Addi) begin
            wr_req = 1'b1;
            wr_val = op_a + imm_i;
         end
      end else if (opc == rvx_pkg::OpcBranch) begin
         if (f3 == rvx_pkg::F3Beq && op_a == op_b) begin
            out_in.branch_taken = 1'b1;
            out_in.next_pc = pc_ff + imm_b;
         end
      end else begin
         // unsupported opcode: hold pc, report nothing else
         out_in.unsupported = 1'b1;
         out_in.next_pc = pc_ff;
      end
      // drop writes to x0
      if (wr_req && rd != '0) begin
         out_in.wrote_reg  = 1'b1;
         out_in.dest_index = rd;
         out_in.dest_value = wr_val;
      end
   end

   assign wr_fire = s1_advance && out_in.wrote_reg;
   assign pc_in   = s1_advance ? out_in.next_pc : pc_ff;

   // -------------------------------------------------------------------------
   // Register file memory: write back from execute, read for the new item
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         gpr_mem_ff[out_in.dest_index] <= out_in.dest_value;
      end
      if (req_accept) begin
         s1_rs1_raw_ff <= gpr_mem_ff[req_rs1];
         s1_rs2_raw_ff <= gpr_mem_ff[req_rs2];
         s1_rs1_ok_ff  <= gpr_ok_ff[req_rs1];
         s1_rs2_ok_ff  <= gpr_ok_ff[req_rs2];
         s1_instr_ff   <= req_instr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_ok_ff <= '0;
         fwd_en_ff <= 1'b0;
      end else if (wr_fire) begin
         gpr_ok_ff[out_in.dest_index] <= 1'b1;
         fwd_en_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         fwd_idx_ff <= out_in.dest_index;
         fwd_val_ff <= out_in.dest_value;
      end
   end

   // -------------------------------------------------------------------------
   // Control state: pc and stage valid flags
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_ff <= out_in;
      end
   end

   // -------------------------------------------------------------------------
   // Response ports
   // -------------------------------------------------------------------------
   assign rsp_valid        = out_valid_ff;
   assign rsp_next_pc      = out_ff.next_pc;
   assign rsp_wrote_reg    = out_ff.wrote_reg;
   assign rsp_dest_index   = out_ff.dest_index;
   assign rsp_dest_value   = out_ff.dest_value;
   assign rsp_branch_taken = out_ff.branch_taken;
   assign rsp_unsupported  = out_ff.unsupported;

endmodule
`default_nettype wire

/* sim/rvx_exec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_exec_checker: retirement checker for the RV32I subset execute unit
// Watches both channels, runs a shadow register file and pc on every accepted
// instruction and compares each returned item with the oldest prediction.
// ----------------------------------------------------------------------------
module rvx_exec_checker
   import rvx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire word_type    req_instr_word,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire word_type    rsp_next_pc,
   input  wire logic        rsp_wrote_reg,
   input  wire reg_idx_type rsp_dest_index,
   input  wire word_type    rsp_dest_value,
   input  wire logic        rsp_branch_taken,
   input  wire logic        rsp_unsupported,
   output int               mismatch_count,
   output int               inflight_count,
   output int               retired_count,
   output int               write_count,
   output int               taken_count,
   output int               unsup_count
);

   word_type        gpr_shadow [RegCount];
   word_type        pc_shadow;
   exec_result_type retire_q [$];

   // Execute one instruction on the shadow state and return its retirement.
   function automatic exec_result_type execute_instr(input word_type w);
      opcode_type      opc;
      funct3_type      f3;
      funct7_type      f7;
      reg_idx_type     rd;
      reg_idx_type     rs1;
      reg_idx_type     rs2;
      word_type        a;
      word_type        b;
      word_type        val;
      logic            wr;
      exec_result_type r;
      opc = w[6:0];
      rd  = w[11:7];
      f3  = w[14:12];
      rs1 = w[19:15];
      rs2 = w[24:20];
      f7  = w[31:25];
      a   = (rs1 == '0) ? '0 : gpr_shadow[rs1];
      b   = (rs2 == '0) ? '0 : gpr_shadow[rs2];
      r   = '0;
      wr  = 1'b0;
      val = '0;
      r.next_pc = pc_shadow + PcStep;
      if (opc == OpcOp) begin
         if (f3 == F3AddSub && f7 == F7Base) begin
            wr = 1'b1;
            val = a + b;
         end else if (f3 == F3AddSub && f7 == F7Alt) begin
            wr = 1'b1;
            val = a - b;
         end else if (f3 == F3And && f7 == F7Base) begin
            wr = 1'b1;
            val = a & b;
         end else if (f3 == F3Or && f7 == F7Base) begin
            wr = 1'b1;
            val = a | b;
         end
      end else if (opc == OpcOpImm) begin
         if (f3 == F3Addi) begin
            wr = 1'b1;
            val = a + {{20{w[31]}}, w[31:20]};
         end
      end else if (opc == OpcBranch) begin
         if (f3 == F3Beq && a == b) begin
            r.branch_taken = 1'b1;
            r.next_pc = pc_shadow + {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         end
      end else begin
         // unknown opcode: pc holds, nothing else reported
         r.unsupported = 1'b1;
         r.next_pc = pc_shadow;
      end
      if (wr && rd != '0) begin
         gpr_shadow[rd] = val;
         r.wrote_reg = 1'b1;
         r.dest_index = rd;
         r.dest_value = val;
      end
      pc_shadow = r.next_pc;
      return r;
   endfunction

   task automatic check_field(input string name, input word_type want, input word_type got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      exec_result_type want;
      if (reset) begin
         retire_q.delete();
         foreach (gpr_shadow[i]) gpr_shadow[i] = '0;
         pc_shadow = '0;
         mismatch_count = 0;
         retired_count = 0;
         write_count = 0;
         taken_count = 0;
         unsup_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (retire_q.size() == 0) begin
               $error("result with no instruction pending: next_pc 0x%h", rsp_next_pc);
               mismatch_count++;
            end else begin
               want = retire_q.pop_front();
               check_field("next_pc", want.next_pc, rsp_next_pc);
               check_field("wrote_reg", word_type'(want.wrote_reg),
                           word_type'(rsp_wrote_reg));
               check_field("dest_index", word_type'(want.dest_index),
                           word_type'(rsp_dest_index));
               check_field("dest_value", want.dest_value, rsp_dest_value);
               check_field("branch_taken", word_type'(want.branch_taken),
                           word_type'(rsp_branch_taken));
               check_field("unsupported", word_type'(want.unsupported),
                           word_type'(rsp_unsupported));
               retired_count++;
               write_count += int'(want.wrote_reg);
               taken_count += int'(want.branch_taken);
               unsup_count += int'(want.unsupported);
            end
         end
         if (req_valid && !req_stall) begin
            retire_q.push_back(execute_instr(req_instr_word));
         end
      end
      inflight_count = retire_q.size();
   end

endmodule

/* sim/rv32i_subset_execute_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit_tb: testbench for the RV32I subset execute unit
// Feeds a directed instruction program and then a long random mix of
// well-formed and malformed instructions under random sender gaps and
// receiver stalls; a separate checker predicts and compares every item.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_unit_tb;
   import rvx_pkg::*;

   localparam int ClockPeriodNs = 12;
   localparam int ResetCycles   = 8;
   localparam int RandomItems   = 1250;
   localparam int MaxGapCycles  = 6;
   localparam int HoldoffCycles = 80;
   localparam int DrainAtItem   = 700;
   localparam int DrainCycles   = 8;
   localparam int TimeoutNs     = 5_000_000;

   // Codes outside the supported subset, used to reach the rejection paths.
   localparam opcode_type OpcLui     = 7'h37;
   localparam opcode_type OpcAllOnes = 7'h7F;
   localparam opcode_type OpcZero    = 7'h00;
   localparam funct3_type F3Sll      = 3'd1;
   localparam funct3_type F3Slti     = 3'd2;
   localparam funct3_type F3Bne      = 3'd1;
   localparam funct7_type F7Odd      = 7'h01;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   word_type    req_instr_word;
   logic        rsp_valid;
   logic        rsp_stall;
   word_type    rsp_next_pc;
   logic        rsp_wrote_reg;
   reg_idx_type rsp_dest_index;
   word_type    rsp_dest_value;
   logic        rsp_branch_taken;
   logic        rsp_unsupported;

   int          mismatch_count;
   int          inflight_count;
   int          retired_count;
   int          write_count;
   int          taken_count;
   int          unsup_count;

   int unsigned burst_left;

   rv32i_subset_execute_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_instr_word  (req_instr_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_wrote_reg   (rsp_wrote_reg),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_dest_value  (rsp_dest_value),
      .rsp_branch_taken(rsp_branch_taken),
      .rsp_unsupported (rsp_unsupported)
   );

   rvx_exec_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_instr_word  (req_instr_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_next_pc     (rsp_next_pc),
      .rsp_wrote_reg   (rsp_wrote_reg),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_dest_value  (rsp_dest_value),
      .rsp_branch_taken(rsp_branch_taken),
      .rsp_unsupported (rsp_unsupported),
      .mismatch_count  (mismatch_count),
      .inflight_count  (inflight_count),
      .retired_count   (retired_count),
      .write_count     (write_count),
      .taken_count     (taken_count),
      .unsup_count     (unsup_count)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriodNs / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Instruction encoders
   // ---------------------------------------------------------------------
   function automatic word_type enc_r(input funct7_type f7, input reg_idx_type rs2,
                                      input reg_idx_type rs1, input funct3_type f3,
                                      input reg_idx_type rd);
      return {f7, rs2, rs1, f3, rd, OpcOp};
   endfunction

   function automatic word_type enc_i(input logic [11:0] imm, input reg_idx_type rs1,
                                      input funct3_type f3, input reg_idx_type rd);
      return {imm, rs1, f3, rd, OpcOpImm};
   endfunction

   // Branch offset is in bytes; bit 0 has no place in the encoding.
   function automatic word_type enc_b(input logic [12:0] off, input reg_idx_type rs2,
                                      input reg_idx_type rs1, input funct3_type f3);
      return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OpcBranch};
   endfunction

   // Favor x0..x3 so results feed later instructions and branches compare
   // equal across different registers.
   function automatic reg_idx_type pick_reg();
      return ($urandom_range(9) < 7) ? reg_idx_type'($urandom_range(3))
                                     : reg_idx_type'($urandom);
   endfunction

   // Random instruction: mostly well-formed subset instructions with random
   // operands, some malformed function codes and some raw noise words.
   function automatic word_type random_instr();
      int unsigned  sel;
      word_type     w;
      logic [11:0]  imm;
      logic [12:0]  off;
      reg_idx_type  rs1;
      reg_idx_type  rs2;
      sel = $urandom_range(99);
      rs1 = pick_reg();
      rs2 = pick_reg();
      if (sel < 30) begin
         case ($urandom_range(3))
            0:       return enc_r(F7Base, rs2, rs1, F3AddSub, pick_reg());
            1:       return enc_r(F7Alt, rs2, rs1, F3AddSub, pick_reg());
            2:       return enc_r(F7Base, rs2, rs1, F3And, pick_reg());
            default: return enc_r(F7Base, rs2, rs1, F3Or, pick_reg());
         endcase
      end else if (sel < 55) begin
         // small immediates keep values colliding; full ones hit the extremes
         if ($urandom_range(1) != 0) imm = 12'($urandom_range(16)) - 12'd8;
         else imm = 12'($urandom);
         return enc_i(imm, rs1, F3Addi, pick_reg());
      end else if (sel < 78) begin
         if ($urandom_range(1) != 0) rs2 = rs1;
         if ($urandom_range(1) != 0) off = (13'($urandom_range(16)) - 13'd8) << 1;
         else off = 13'($urandom);
         return enc_b(off, rs2, rs1, F3Beq);
      end else if (sel < 90) begin
         w = $urandom;
         case ($urandom_range(3))
            0: begin
               // funct3 of 1..5 has no R-type operation here
               w[6:0] = OpcOp;
               w[14:12] = funct3_type'($urandom_range(5, 1));
            end
            1: begin
               // odd funct7 never matches base or alternate
               w[6:0] = OpcOp;
               w[14:12] = ($urandom_range(2) == 0) ? F3AddSub :
                          ($urandom_range(1) == 0) ? F3And : F3Or;
               w[31:25] = funct7_type'($urandom) | F7Odd;
            end
            2: begin
               w[6:0] = OpcOpImm;
               w[14:12] = funct3_type'($urandom_range(7, 1));
            end
            default: begin
               w[6:0] = OpcBranch;
               w[14:12] = funct3_type'($urandom_range(7, 1));
               if ($urandom_range(1) != 0) w[24:20] = w[19:15];
            end
         endcase
         return w;
      end
      return $urandom;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: offer one item, idling in random bursts. Call at a falling edge;
   // returns at the falling edge after acceptance.
   // ---------------------------------------------------------------------
   task automatic offer_instr(input word_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(MaxGapCycles, 1);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         // occasional long bursts give stretches with no sender idling
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20)
                                               : $urandom_range(8, 1);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_instr_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus and verdict
   // ---------------------------------------------------------------------
   initial begin : stimulus
      word_type directed_prog [$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_instr_word = '0;
      burst_left = 0;
      directed_prog = '{
         enc_i(12'h7FF, 5'd0, F3Addi, 5'd1),           // largest positive immediate
         enc_i(12'h800, 5'd0, F3Addi, 5'd2),           // most negative immediate
         enc_i(12'hFFF, 5'd0, F3Addi, 5'd3),           // minus one
         enc_r(F7Base, 5'd2, 5'd1, F3AddSub, 5'd4),    // ADD
         enc_r(F7Alt, 5'd1, 5'd2, F3AddSub, 5'd5),     // SUB
         enc_r(F7Base, 5'd1, 5'd3, F3And, 5'd6),       // AND
         enc_r(F7Base, 5'd1, 5'd2, F3Or, 5'd7),        // OR
         enc_r(F7Alt, 5'd3, 5'd0, F3AddSub, 5'd8),     // SUB from x0
         enc_r(F7Base, 5'd1, 5'd1, F3AddSub, 5'd0),    // write to x0 dropped
         enc_i(12'd5, 5'd3, F3Addi, 5'd0),             // ADDI to x0 dropped
         enc_i(12'd1, 5'd31, F3Addi, 5'd31),           // top register
         enc_b(13'd8, 5'd3, 5'd4, F3Beq),              // taken, forward
         enc_b(13'd8, 5'd2, 5'd1, F3Beq),              // not equal
         enc_b(13'h1000, 5'd0, 5'd0, F3Beq),           // most negative offset, pc wraps
         enc_b(13'h0FFE, 5'd0, 5'd0, F3Beq),           // largest positive offset
         enc_r(F7Base, 5'd2, 5'd1, F3Sll, 5'd9),       // unmatched funct3
         enc_r(F7Odd, 5'd2, 5'd1, F3AddSub, 5'd9),     // unmatched funct7
         enc_r(F7Alt, 5'd2, 5'd1, F3And, 5'd9),        // AND needs base funct7
         enc_r(F7Alt, 5'd2, 5'd1, F3Or, 5'd9),         // OR needs base funct7
         enc_i(12'd7, 5'd1, F3Slti, 5'd9),             // OP-IMM but not ADDI
         enc_b(13'd16, 5'd0, 5'd0, F3Bne),             // branch but not BEQ
         {25'h0000000, OpcZero},                       // all-zero word
         {25'h1FFFFFF, OpcAllOnes},                    // all-ones word
         {20'hABCDE, 5'd5, OpcLui},                    // LUI is outside the subset
         {25'h1FFFFFF, OpcOp},                         // every R-type field at its top
         enc_r(F7Base, 5'd0, 5'd31, F3AddSub, 5'd10)   // read back x31
      };

      // Hold reset, release it at a falling edge.
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_prog[i]) offer_instr(directed_prog[i]);

      for (int n = 0; n < RandomItems; n++) begin
         if (n == DrainAtItem) begin
            // Pause the sender until every outstanding item has returned.
            req_valid <= 1'b0;
            @(negedge clock);
            while (inflight_count != 0) @(negedge clock);
         end
         offer_instr(random_instr());
      end

      // Drop valid, wait for the pipeline to empty, then go on watching for
      // stray results.
      req_valid <= 1'b0;
      while (inflight_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("Retired %0d instructions (%0d directed, %0d random) under sender gaps,",
               retired_count, directed_prog.size(), RandomItems);
      $display("receiver stalls and long hold-offs: %0d writes, %0d taken branches,",
               write_count, taken_count);
      $display("%0d unsupported.", unsup_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: stall in segments of random density, and twice hold off for
   // a long stretch so the block fills up and stalls its input.
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      int unsigned pct;
      int unsigned seg_len;
      int unsigned seg;
      rsp_stall = 1'b0;
      seg = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (seg == 3 || seg == 25) begin
            rsp_stall <= 1'b1;
            repeat (HoldoffCycles) @(negedge clock);
         end
         case ($urandom_range(4))
            0, 1:    pct = 0;
            2:       pct = 20;
            3:       pct = 50;
            default: pct = 85;
         endcase
         seg_len = $urandom_range(60, 8);
         repeat (seg_len) begin
            rsp_stall <= ($urandom_range(99) < pct);
            @(negedge clock);
         end
         seg++;
      end
   end

   // Bound the run in case the block hangs.
   initial begin : watchdog
      #(TimeoutNs);
      $display("Test completed with failures");
      $finish;
   end

endmodule
